// ===== src/polled_point_value_cache_core_assert.svh =====
// Assertion macros for the polled point value cache checker.
`ifndef POLLED_POINT_VALUE_CACHE_CORE_ASSERT_SVH
`define POLLED_POINT_VALUE_CACHE_CORE_ASSERT_SVH

// Condition must hold in the same cycle as the trigger.
`define PPVC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition must hold in the cycle after the trigger.
`define PPVC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ppvc_pkg.sv =====
// Shared types, constants and helpers of the polled point value cache.
package ppvc_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  localparam int KIND_W = 3;
  localparam int DEV_W  = 22;
  localparam int TYPE_W = 10;
  localparam int INST_W = 22;
  localparam int TAG_W  = 4;
  localparam int VAL_W  = 32;
  localparam int MS_W   = 27;

  localparam logic [MS_W-1:0]  POLL_RESET_MS = MS_W'(1 * 60 * 1000);
  localparam logic [IDX_W-1:0] LAST_IDX      = IDX_W'(ENTRIES - 1);

  // Application tags kept as present value
  localparam logic [TAG_W-1:0] TAG_UNSIGNED = TAG_W'(2);
  localparam logic [TAG_W-1:0] TAG_REAL     = TAG_W'(4);
  localparam logic [TAG_W-1:0] TAG_ENUM     = TAG_W'(9);

  // Supported object types
  localparam logic [TYPE_W-1:0] OBJ_BASIC_MAX = TYPE_W'(5);
  localparam logic [TYPE_W-1:0] OBJ_MSI       = TYPE_W'(13);
  localparam logic [TYPE_W-1:0] OBJ_MSO       = TYPE_W'(14);
  localparam logic [TYPE_W-1:0] OBJ_MSV       = TYPE_W'(19);

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD   = 3'd0,
    KIND_SAVE  = 3'd1,
    KIND_QUERY = 3'd2,
    KIND_TICK  = 3'd3,
    KIND_POLL  = 3'd4
  } kind_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DEV_W-1:0]  dev_inst;
    logic [TYPE_W-1:0] obj_type;
    logic [INST_W-1:0] obj_inst;
    logic              read_ok;
    logic              is_present_value;
    logic              ctx_tagged;
    logic [TAG_W-1:0]  value_tag;
    logic [VAL_W-1:0]  value_bits;
  } in_item_t;

  typedef struct packed {
    logic              ok;
    logic [VAL_W-1:0]  stored_bits;
    logic [TAG_W-1:0]  stored_tag;
    logic              binary_active;
    logic              poll_valid;
    logic [DEV_W-1:0]  poll_device;
    logic [TYPE_W-1:0] poll_type;
    logic [INST_W-1:0] poll_instance;
  } out_item_t;

  typedef struct packed {
    logic [DEV_W-1:0]  dev;
    logic [TYPE_W-1:0] typ;
    logic [INST_W-1:0] inst;
  } key_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [VAL_W-1:0] bits;
  } val_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic scan_run;
    logic poll_rd;
    logic act;
    logic out_load;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_end;
  } ctrl_sts_t;

  function automatic logic type_supported(input logic [TYPE_W-1:0] t);
    return (t <= OBJ_BASIC_MAX) || (t == OBJ_MSI) || (t == OBJ_MSO) || (t == OBJ_MSV);
  endfunction

endpackage

// ===== src/ppvc_datapath.sv =====
// Datapath: point tables, scan pipeline, tick counter, poll cursor and result register.
module ppvc_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ppvc_pkg::MS_W-1:0]       cfg_wdata_i,
  input  ppvc_pkg::ctrl_cmd_t             cmd_i,
  output ppvc_pkg::ctrl_sts_t             sts_o,
  input  ppvc_pkg::in_item_t              in_data_i,
  output ppvc_pkg::out_item_t             out_data_o
);
  import ppvc_pkg::*;

  in_item_t          item_q;
  logic [MS_W-1:0]   cfg_q;
  logic [MS_W-1:0]   ms_q, ms_d;
  logic [IDX_W-1:0]  cursor_q, cursor_d;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [ENTRIES-1:0] refresh_q, refresh_d;
  logic [ENTRIES-1:0] written_q, written_d;

  key_t              kmem [ENTRIES];
  key_t              key_rd_q;
  val_t              vmem [ENTRIES];
  val_t              val_rd_q;
  logic              val_ok_q;

  logic [CNT_W-1:0]  scan_cnt_q;
  logic              p_vld_q;
  logic [IDX_W-1:0]  p_idx_q;
  logic              hit_q;
  logic [IDX_W-1:0]  hit_idx_q;
  logic              free_fnd_q;
  logic [IDX_W-1:0]  free_idx_q;

  out_item_t         res_q, res_d;
  logic              qhit_q, qhit_d;
  out_item_t         out_q, out_d;

  key_t              item_key;
  logic              cmp_hit;
  logic              issue;
  logic [IDX_W-1:0]  iss_idx;
  logic [IDX_W-1:0]  kmem_raddr;
  logic              kmem_re;
  logic              kmem_we;
  logic              vmem_we;
  logic              supported;
  logic              tag_ok;
  logic [MS_W-1:0]   ms_inc;

  assign item_key   = '{dev: item_q.dev_inst, typ: item_q.obj_type,
                        inst: item_q.obj_inst};
  assign cmp_hit    = p_vld_q && valid_q[p_idx_q] && (key_rd_q == item_key);
  assign issue      = cmd_i.scan_run && (scan_cnt_q < CNT_W'(ENTRIES));
  assign iss_idx    = scan_cnt_q[IDX_W-1:0];
  assign kmem_raddr = cmd_i.poll_rd ? cursor_q : iss_idx;
  assign kmem_re    = issue || cmd_i.poll_rd;
  assign sts_o.scan_end = p_vld_q && (cmp_hit || (p_idx_q == LAST_IDX));

  assign supported = type_supported(item_q.obj_type);
  assign tag_ok    = (item_q.value_tag == TAG_UNSIGNED) || (item_q.value_tag == TAG_REAL) ||
                     (item_q.value_tag == TAG_ENUM);
  assign ms_inc    = ms_q + MS_W'(1);

  always_comb begin
    valid_d   = valid_q;
    refresh_d = refresh_q;
    written_d = written_q;
    ms_d      = ms_q;
    cursor_d  = cursor_q;
    kmem_we   = 1'b0;
    vmem_we   = 1'b0;
    res_d     = res_q;
    qhit_d    = qhit_q;
    if (cmd_i.act) begin
      res_d  = '0;
      qhit_d = 1'b0;
      case (kind_e'(item_q.kind))
        KIND_ADD, KIND_QUERY: begin
          if ((kind_e'(item_q.kind) == KIND_QUERY) && hit_q) begin
            res_d.ok = 1'b1;
            qhit_d   = 1'b1;
          end else if (supported) begin
            if (hit_q) begin
              refresh_d[hit_idx_q] = 1'b1;
              res_d.ok = 1'b1;
            end else if (free_fnd_q) begin
              valid_d[free_idx_q]   = 1'b1;
              refresh_d[free_idx_q] = 1'b1;
              kmem_we  = 1'b1;
              res_d.ok = (kind_e'(item_q.kind) == KIND_ADD);
            end
          end
        end
        KIND_SAVE: begin
          if (item_q.read_ok && hit_q) begin
            res_d.ok = 1'b1;
            if (!item_q.ctx_tagged) begin
              if (item_q.is_present_value && tag_ok) begin
                vmem_we = 1'b1;
                written_d[hit_idx_q] = 1'b1;
              end
              refresh_d[hit_idx_q] = 1'b0;
            end
          end
        end
        KIND_TICK: begin
          // an interval of zero behaves as one
          if (ms_inc >= cfg_q) begin
            ms_d      = '0;
            refresh_d = '1;
          end else begin
            ms_d = ms_inc;
          end
        end
        KIND_POLL: begin
          if (refresh_q[cursor_q]) begin
            refresh_d[cursor_q] = 1'b0;
            if (valid_q[cursor_q]) begin
              res_d.poll_valid    = 1'b1;
              res_d.poll_device   = key_rd_q.dev;
              res_d.poll_type     = key_rd_q.typ;
              res_d.poll_instance = key_rd_q.inst;
            end
          end
          cursor_d = (cursor_q == LAST_IDX) ? '0 : cursor_q + IDX_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // a slot never saved reads as zero
  always_comb begin
    out_d = res_q;
    if (qhit_q && val_ok_q) begin
      out_d.stored_bits   = val_rd_q.bits;
      out_d.stored_tag    = val_rd_q.tag;
      out_d.binary_active = (val_rd_q.bits != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q      <= POLL_RESET_MS;
      ms_q       <= '0;
      cursor_q   <= '0;
      valid_q    <= '0;
      refresh_q  <= '0;
      written_q  <= '0;
      scan_cnt_q <= '0;
      p_vld_q    <= 1'b0;
      hit_q      <= 1'b0;
      free_fnd_q <= 1'b0;
      qhit_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      ms_q      <= ms_d;
      cursor_q  <= cursor_d;
      valid_q   <= valid_d;
      refresh_q <= refresh_d;
      written_q <= written_d;
      qhit_q    <= qhit_d;
      if (cmd_i.load) begin
        scan_cnt_q <= '0;
        p_vld_q    <= 1'b0;
        hit_q      <= 1'b0;
        free_fnd_q <= 1'b0;
      end else if (cmd_i.scan_run) begin
        p_vld_q <= issue;
        if (issue) begin
          scan_cnt_q <= scan_cnt_q + CNT_W'(1);
          if (!valid_q[iss_idx] && !free_fnd_q) begin
            free_fnd_q <= 1'b1;
          end
        end
        if (cmp_hit) begin
          hit_q <= 1'b1;
        end
      end
    end
  end

  // payload registers and memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
    if (cmd_i.scan_run) begin
      p_idx_q <= iss_idx;
      if (issue && !valid_q[iss_idx] && !free_fnd_q) begin
        free_idx_q <= iss_idx;
      end
      if (cmp_hit) begin
        hit_idx_q <= p_idx_q;
      end
    end
    if (kmem_we) begin
      kmem[free_idx_q] <= item_key;
    end
    if (kmem_re) begin
      key_rd_q <= kmem[kmem_raddr];
    end
    if (vmem_we) begin
      vmem[hit_idx_q] <= '{tag: item_q.value_tag, bits: item_q.value_bits};
    end
    if (cmd_i.act) begin
      val_rd_q <= vmem[hit_idx_q];
      val_ok_q <= written_q[hit_idx_q];
    end
    res_q <= res_d;
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== src/ppvc_ctrl.sv =====
// Controller: sequences accept, table scan, poll read, update and result hand-off.
module ppvc_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ppvc_pkg::KIND_W-1:0]   in_kind_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ppvc_pkg::ctrl_cmd_t           cmd_o,
  input  ppvc_pkg::ctrl_sts_t           sts_i
);
  import ppvc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_POLL_RD,
    ST_ACT,
    ST_FIN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = in_valid_i && (state_q == ST_IDLE);
    cmd_o.scan_run = (state_q == ST_SCAN);
    cmd_o.poll_rd  = (state_q == ST_POLL_RD);
    cmd_o.act      = (state_q == ST_ACT);
    cmd_o.out_load = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.load) begin
          case (kind_e'(in_kind_i))
            KIND_ADD, KIND_SAVE, KIND_QUERY: state_d = ST_SCAN;
            KIND_POLL:                       state_d = ST_POLL_RD;
            default:                         state_d = ST_ACT;
          endcase
        end
      end
      ST_SCAN: begin
        if (sts_i.scan_end) begin
          state_d = ST_ACT;
        end
      end
      ST_POLL_RD: state_d = ST_ACT;
      ST_ACT:     state_d = ST_FIN;
      ST_FIN: begin
        if (cmd_o.out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // hold the result until taken
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== src/polled_point_value_cache_core.sv =====
// Add, save and query walk the 16-entry key table, one entry a cycle through one read port;
//   the walk ends at the last entry or earlier on a match, then the update and result steps follow.
// Ticks go straight to the update step and poll slots read the key first; one item is in work at a
//   time and the next is taken the cycle after its result enters the output register.
// Reset: control, valid, refresh and saved flags, cursor and tick count clear; interval is 60000 ms.
module polled_point_value_cache_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [ppvc_pkg::MS_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  ppvc_pkg::in_item_t        in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output ppvc_pkg::out_item_t       out_data_o
);
  import ppvc_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  ppvc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_kind_i   (in_data_i.kind),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  ppvc_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== src/ppvc_checker.sv =====
// Port-level checker for the polled point value cache, bound to the top level.
`include "polled_point_value_cache_core_assert.svh"

module ppvc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input ppvc_pkg::out_item_t out_data_o
);
  import ppvc_pkg::*;

  logic in_take;
  logic out_stall;
  logic poll_out;
  logic poll_clean;
  logic active_ok;

  assign in_take    = in_valid_i && in_ready_o;
  assign out_stall  = out_valid_o && !out_ready_i;
  assign poll_out   = out_valid_o && out_data_o.poll_valid;
  assign poll_clean = !out_data_o.ok && (out_data_o.stored_bits == '0);
  assign active_ok  = out_data_o.binary_active == (out_data_o.stored_bits != '0);

  `PPVC_ASSERT_NEXT(a_out_hold, out_stall, out_valid_o && $stable(out_data_o), "result not held")
  `PPVC_ASSERT_NEXT(a_one_in_flight, in_take, !in_ready_o, "second item taken while busy")
  `PPVC_ASSERT_NOW(a_poll_only, poll_out, poll_clean, "poll result mixed with lookup fields")
  `PPVC_ASSERT_NOW(a_active_match, out_valid_o, active_ok, "binary flag disagrees with value")

endmodule

bind polled_point_value_cache_core ppvc_checker u_ppvc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
